FILE: rtl/fbpc_pkg.sv
// ----------------------------------------------------------------------------
// fbpc_pkg
// Shared widths, item kinds and plane layout for the frustum cull pipeline.
// ----------------------------------------------------------------------------
package fbpc_pkg;

  localparam int COORD_BITS  = 24;
  localparam int MATRIX_BITS = 24;

  localparam int MTX_DEPTH  = 16;
  localparam int IDX_W      = $clog2(MTX_DEPTH);
  localparam int NUM_PLANES = 6;
  localparam int NUM_AXES   = 3;

  // Q8.16 elements times Q16.8 coordinates give Q.24; d is aligned up by 8.
  localparam int D_SHIFT = 8;

  localparam int NRM_W  = MATRIX_BITS + 1;
  localparam int PROD_W = NRM_W + COORD_BITS;
  localparam int SUM_W  = PROD_W + 2;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_BOX   = 2'd1,
    KIND_POINT = 2'd2
  } kind_t;

  typedef logic signed [COORD_BITS-1:0]  coord_t;
  typedef logic signed [MATRIX_BITS-1:0] elem_t;
  typedef logic signed [NRM_W-1:0]       nrm_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

endpackage

FILE: rtl/frustum_box_point_cull.sv
// ----------------------------------------------------------------------------
// frustum_box_point_cull
// View-frustum visibility test for axis-aligned boxes and points against the
// six planes drawn from a loaded 4x4 view-projection matrix.
//
//   channel  direction  fields
//   in_      input      kind, element_index, element_value, low_*, high_*
//   out_     output     visible (one word per box or point test)
//
// One word is taken per cycle while in_stall is low. A test word passes
// the input, plane/vertex, multiply, sum and output registers to reach out_.
// A load word updates the matrix at once and gives no result; tests taken
// later use the new element. Kind 3 is taken and dropped.
// Reset clears the matrix to zero, so every test then reports visible.
// Each stage advances when its successor has room; out_stall backs up
// only as far as the first empty stage.
// ----------------------------------------------------------------------------
module frustum_box_point_cull
  import fbpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_kind,
  input  logic [IDX_W-1:0]       in_element_index,
  input  logic signed [MATRIX_BITS-1:0] in_element_value,
  input  logic signed [COORD_BITS-1:0]  in_low_x,
  input  logic signed [COORD_BITS-1:0]  in_low_y,
  input  logic signed [COORD_BITS-1:0]  in_low_z,
  input  logic signed [COORD_BITS-1:0]  in_high_x,
  input  logic signed [COORD_BITS-1:0]  in_high_y,
  input  logic signed [COORD_BITS-1:0]  in_high_z,

  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_visible
);

  elem_t  mtx_r [MTX_DEPTH];

  logic   v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic   rdy1, rdy2, rdy3, rdy4, rdy_out;
  logic   in_take, load_take, test_take;

  logic   box1_r;
  coord_t lo1_r [NUM_AXES];
  coord_t hi1_r [NUM_AXES];

  nrm_t   n2_nxt [NUM_PLANES][NUM_AXES];
  nrm_t   d2_nxt [NUM_PLANES];
  coord_t p2_nxt [NUM_PLANES][NUM_AXES];
  nrm_t   n2_r   [NUM_PLANES][NUM_AXES];
  nrm_t   d2_r   [NUM_PLANES];
  coord_t p2_r   [NUM_PLANES][NUM_AXES];

  prod_t  prod3_nxt [NUM_PLANES][NUM_AXES];
  prod_t  prod3_r   [NUM_PLANES][NUM_AXES];
  nrm_t   d3_r      [NUM_PLANES];

  logic [NUM_PLANES-1:0] behind4_nxt;
  logic [NUM_PLANES-1:0] behind4_r;

  logic   out_visible_r;

  // Handshake and stage flow.
  assign rdy_out   = !out_valid_r || !out_stall;
  assign rdy4      = !v4_r || rdy_out;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_stall  = !rdy1;
  assign in_take   = in_valid && rdy1;
  assign load_take = in_take && (in_kind == KIND_LOAD);
  assign test_take = in_take && ((in_kind == KIND_BOX) || (in_kind == KIND_POINT));

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MTX_DEPTH; i++) begin
        mtx_r[i] <= '0;
      end
    end else if (load_take) begin
      mtx_r[in_element_index] <= in_element_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= test_take;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
      if (rdy_out) begin
        out_valid_r <= v4_r;
      end
    end
  end

  // Stage 1: hold the test word.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      box1_r   <= (in_kind == KIND_BOX);
      lo1_r[0] <= in_low_x;
      lo1_r[1] <= in_low_y;
      lo1_r[2] <= in_low_z;
      hi1_r[0] <= in_high_x;
      hi1_r[1] <= in_high_y;
      hi1_r[2] <= in_high_z;
    end
  end

  // Stage 2: form planes from row 3 plus or minus rows 0..2, pick vertices.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int s = 0; s < 2; s++) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          if (s == 0) begin
            n2_nxt[k*2+s][a] = NRM_W'(mtx_r[IDX_W'(a*4+3)]) + NRM_W'(mtx_r[IDX_W'(a*4+k)]);
          end else begin
            n2_nxt[k*2+s][a] = NRM_W'(mtx_r[IDX_W'(a*4+3)]) - NRM_W'(mtx_r[IDX_W'(a*4+k)]);
          end
          p2_nxt[k*2+s][a] = (box1_r && !n2_nxt[k*2+s][a][NRM_W-1]) ? hi1_r[a] : lo1_r[a];
        end
        if (s == 0) begin
          d2_nxt[k*2+s] = NRM_W'(mtx_r[IDX_W'(15)]) + NRM_W'(mtx_r[IDX_W'(12+k)]);
        end else begin
          d2_nxt[k*2+s] = NRM_W'(mtx_r[IDX_W'(15)]) - NRM_W'(mtx_r[IDX_W'(12+k)]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      n2_r <= n2_nxt;
      p2_r <= p2_nxt;
      d2_r <= d2_nxt;
    end
  end

  // Stage 3: multiply each normal component by its vertex coordinate.
  always_comb begin
    for (int j = 0; j < NUM_PLANES; j++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        prod3_nxt[j][a] = PROD_W'(n2_r[j][a]) * PROD_W'(p2_r[j][a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      prod3_r <= prod3_nxt;
      d3_r    <= d2_r;
    end
  end

  // Stage 4: exact n.p + d per plane, keep the sign.
  always_comb begin
    sum_t acc;
    acc = '0;
    for (int j = 0; j < NUM_PLANES; j++) begin
      acc = (SUM_W'(d3_r[j]) <<< D_SHIFT) + SUM_W'(prod3_r[j][0])
          + SUM_W'(prod3_r[j][1]) + SUM_W'(prod3_r[j][2]);
      behind4_nxt[j] = acc[SUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      behind4_r <= behind4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_visible_r <= ~|behind4_r;
    end
  end

  a_load_writes: assert property (@(posedge clk) disable iff (!rst_n)
    load_take |=> mtx_r[$past(in_element_index)] == $past(in_element_value))
    else $error("matrix element not written by load word");

  a_test_enters: assert property (@(posedge clk) disable iff (!rst_n)
    test_take |=> v1_r)
    else $error("test word lost at pipeline entry");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && out_valid_r))
    else $error("input stalled with an empty stage");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (load_take && !v1_r) |=> !v1_r)
    else $error("load word entered the test pipeline");

endmodule

FILE: sim/fbpc_cull_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpc_cull_checker
// Watches both channels of the frustum cull block. It keeps its own copy of
// the matrix and works out the visibility of every box or point test with
// exact 64-bit sums. It then checks each result word in order against the
// oldest prediction.
// ----------------------------------------------------------------------------
module fbpc_cull_checker
  import fbpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [1:0]             in_kind,
  input  logic [IDX_W-1:0]       in_element_index,
  input  elem_t                  in_element_value,
  input  coord_t                 in_low_x,
  input  coord_t                 in_low_y,
  input  coord_t                 in_low_z,
  input  coord_t                 in_high_x,
  input  coord_t                 in_high_y,
  input  coord_t                 in_high_z,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic                   out_visible,
  output int                     errors,
  output int                     pending
);

  elem_t mtx [MTX_DEPTH];
  logic  visible_q [$];
  logic  want;

  function automatic logic predict_visible(input logic is_box,
                                           input coord_t lx, input coord_t ly,
                                           input coord_t lz, input coord_t hx,
                                           input coord_t hy, input coord_t hz);
    longint lo [NUM_AXES];
    longint hi [NUM_AXES];
    longint nrm [NUM_AXES];
    longint row3, rowk, plane_d, acc;
    lo[0] = lx; lo[1] = ly; lo[2] = lz;
    hi[0] = hx; hi[1] = hy; hi[2] = hz;
    for (int k = 0; k < NUM_AXES; k++) begin
      for (int s = 0; s < 2; s++) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          row3 = mtx[a*4+3];
          rowk = mtx[a*4+k];
          nrm[a] = s ? row3 - rowk : row3 + rowk;
        end
        row3 = mtx[15];
        rowk = mtx[12+k];
        plane_d = s ? row3 - rowk : row3 + rowk;
        acc = plane_d <<< D_SHIFT;
        for (int a = 0; a < NUM_AXES; a++)
          acc += nrm[a] * ((is_box && nrm[a] >= 0) ? hi[a] : lo[a]);
        if (acc < 0)
          return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (mtx[i]) mtx[i] = '0;
      visible_q.delete();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (visible_q.size() == 0) begin
          errors++;
          $error("visible: expected none, got %0b", out_visible);
        end else begin
          want = visible_q.pop_front();
          if (out_visible !== want) begin
            errors++;
            $error("visible: expected %0b, got %0b", want, out_visible);
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (in_kind)
          KIND_LOAD: mtx[in_element_index] = in_element_value;
          KIND_BOX: visible_q.push_back(predict_visible(1'b1, in_low_x, in_low_y, in_low_z,
                                                        in_high_x, in_high_y, in_high_z));
          KIND_POINT: visible_q.push_back(predict_visible(1'b0, in_low_x, in_low_y, in_low_z,
                                                          in_high_x, in_high_y, in_high_z));
          default: ;
        endcase
      end
    end
    pending = visible_q.size();
  end

endmodule

FILE: sim/tb_frustum_box_point_cull.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frustum_box_point_cull
// Drives matrix loads and box and point tests into the frustum cull block.
// A directed opening covers empty and degenerate matrices, identity planes,
// inverted boxes, extreme values and the spare kind. Random frustum reloads
// and tests follow, with bursty input, a patterned output stall and one long
// output hold-off. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_frustum_box_point_cull;
  import fbpc_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int     ONE_M        = 1 << 16;
  localparam int     ONE_C        = 1 << 8;
  localparam coord_t C_MAX        = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t C_MIN        = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam elem_t  E_MAX        = {1'b0, {(MATRIX_BITS-1){1'b1}}};
  localparam elem_t  E_MIN        = {1'b1, {(MATRIX_BITS-1){1'b0}}};
  localparam int     RANDOM_WORDS = 1900;
  localparam int     DRAIN_LIMIT  = 5000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_kind = KIND_LOAD;
  logic [IDX_W-1:0] in_element_index = '0;
  elem_t            in_element_value = '0;
  coord_t           in_low_x = '0;
  coord_t           in_low_y = '0;
  coord_t           in_low_z = '0;
  coord_t           in_high_x = '0;
  coord_t           in_high_y = '0;
  coord_t           in_high_z = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_visible;
  int               fail_count;
  int               pending_cnt;
  int               burst_left = 0;

  frustum_box_point_cull DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_element_index(in_element_index), .in_element_value(in_element_value),
    .in_low_x(in_low_x), .in_low_y(in_low_y), .in_low_z(in_low_z),
    .in_high_x(in_high_x), .in_high_y(in_high_y), .in_high_z(in_high_z),
    .out_valid(out_valid), .out_stall(out_stall), .out_visible(out_visible)
  );

  fbpc_cull_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_element_index(in_element_index), .in_element_value(in_element_value),
    .in_low_x(in_low_x), .in_low_y(in_low_y), .in_low_z(in_low_z),
    .in_high_x(in_high_x), .in_high_y(in_high_y), .in_high_z(in_high_z),
    .out_valid(out_valid), .out_stall(out_stall), .out_visible(out_visible),
    .errors(fail_count), .pending(pending_cnt)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("FAIL frustum_box_point_cull");
    $finish;
  end

  function automatic coord_t rand_coord();
    if ($urandom_range(0, 2) == 0)
      return coord_t'($urandom);
    return coord_t'(int'($urandom_range(0, 8192)) - 4096);
  endfunction

  task automatic send_word(input logic [1:0] kind, input logic [IDX_W-1:0] idx,
                           input elem_t val, input coord_t lx, input coord_t ly,
                           input coord_t lz, input coord_t hx, input coord_t hy,
                           input coord_t hz);
    int idle;
    idle = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0)
        idle = $urandom_range(1, 8);
    end
    burst_left--;
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_element_index <= idx;
    in_element_value <= val;
    in_low_x         <= lx;
    in_low_y         <= ly;
    in_low_z         <= lz;
    in_high_x        <= hx;
    in_high_y        <= hy;
    in_high_z        <= hz;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_load(input int idx, input elem_t val);
    send_word(KIND_LOAD, IDX_W'(idx), val, rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic send_test(input logic [1:0] kind, input coord_t lx, input coord_t ly,
                           input coord_t lz, input coord_t hx, input coord_t hy,
                           input coord_t hz);
    send_word(kind, IDX_W'($urandom), elem_t'($urandom), lx, ly, lz, hx, hy, hz);
  endtask

  // receiver: patterned stalls with one long hold-off
  initial begin
    int mode, len, cyc;
    logic held;
    held = 1'b0;
    cyc = 0;
    repeat (6) @(posedge clk);
    forever begin
      if (!held && cyc > 400) begin
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        held = 1'b1;
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(20, 120);
      for (int i = 0; i < len; i++) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 0);
          2: out_stall <= (i % 4 == 3);
          default: out_stall <= ($urandom_range(0, 4) != 0);
        endcase
        @(posedge clk);
        cyc++;
      end
    end
  end

  initial begin
    int words, v, r, waited;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // cleared matrix: everything visible
    send_test(KIND_BOX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
    send_test(KIND_POINT, C_MAX, C_MAX, C_MAX, '0, '0, '0);
    // zero normals with negative d: everything culled
    send_load(15, elem_t'(-1));
    send_test(KIND_POINT, '0, '0, '0, '0, '0, '0);
    send_test(KIND_BOX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
    // identity frustum
    send_load(15, elem_t'(ONE_M));
    send_load(0, elem_t'(ONE_M));
    send_load(5, elem_t'(ONE_M));
    send_load(10, elem_t'(ONE_M));
    send_test(KIND_POINT, '0, '0, '0, '0, '0, '0);
    send_test(KIND_POINT, coord_t'(2 * ONE_C), '0, '0, '0, '0, '0);
    send_test(KIND_BOX, coord_t'(-4 * ONE_C), coord_t'(-4 * ONE_C), coord_t'(-4 * ONE_C),
              coord_t'(4 * ONE_C), coord_t'(4 * ONE_C), coord_t'(4 * ONE_C));
    send_test(KIND_BOX, coord_t'(2 * ONE_C), coord_t'(2 * ONE_C), '0,
              coord_t'(-2 * ONE_C), coord_t'(-2 * ONE_C), '0);
    send_test(KIND_BOX, coord_t'(3 * ONE_C), '0, '0, coord_t'(5 * ONE_C),
              coord_t'(ONE_C), coord_t'(ONE_C));
    send_word(KIND_SPARE, IDX_W'($urandom), E_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
    send_load(3, E_MAX);
    send_load(12, E_MIN);
    send_test(KIND_BOX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
    send_test(KIND_POINT, C_MIN, C_MIN, C_MIN, '0, '0, '0);
    send_test(KIND_POINT, C_MAX, C_MAX, C_MAX, '0, '0, '0);
    send_test(KIND_BOX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);

    words = 0;
    while (words < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) < 7) begin
        for (int i = 0; i < MTX_DEPTH; i++) begin
          if (i % 5 == 0) begin
            v = $urandom_range(ONE_M / 4, 2 * ONE_M);
            if (i != 15 && $urandom_range(0, 4) == 0)
              v = -v;
          end else if (i == 11 && $urandom_range(0, 1) == 0) begin
            v = -ONE_M;
          end else begin
            v = int'($urandom_range(0, ONE_M / 2)) - ONE_M / 4;
          end
          send_load(i, elem_t'(v));
          words++;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_load($urandom_range(0, MTX_DEPTH - 1), elem_t'($urandom));
          words++;
        end
      end
      repeat ($urandom_range(10, 40)) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          send_word(KIND_SPARE, IDX_W'($urandom), elem_t'($urandom), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end else begin
          send_test(r < 11 ? KIND_BOX : KIND_POINT, rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), rand_coord());
          words++;
        end
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    @(negedge clk);
    while (pending_cnt != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (16) @(negedge clk);
    if (pending_cnt != 0)
      $error("visible: %0d expected words never arrived", pending_cnt);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("PASS frustum_box_point_cull");
    end else begin
      $display("FAIL frustum_box_point_cull");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/fbpc_pkg.sv
rtl/frustum_box_point_cull.sv
sim/fbpc_cull_checker.sv
sim/tb_frustum_box_point_cull.sv
